### hw/rtl/bctm_pkg.sv
// bctm_pkg: shared types and constants for the battery cell tap monitor.
// No dependencies.
package bctm_pkg;

    localparam int TAPS = 8;

    localparam logic [2:0] REG_SCALE   = 3'd0;
    localparam logic [2:0] REG_UNDER   = 3'd1;
    localparam logic [2:0] REG_OVER    = 3'd2;
    localparam logic [2:0] REG_GROUP_A = 3'd3;
    localparam logic [2:0] REG_GROUP_B = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WRITE,
        ST_SUM,
        ST_DIV,
        ST_MUL,
        ST_CELL,
        ST_STATS,
        ST_EMIT
    } state_t;

    // request from sequencer to the divider; dividend covers a 64-deep window sum << 8
    typedef struct packed {
        logic        start;
        logic [28:0] dividend;
        logic [6:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [28:0] quotient;
    } div_rsp_t;

endpackage

### hw/rtl/bctm_divider.sv
// bctm_divider: restoring divider, one quotient bit per cycle.
// Depends on bctm_pkg.
module bctm_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  bctm_pkg::div_req_t  req,
    output bctm_pkg::div_rsp_t  rsp
);

    logic [28:0] quot_reg, quot_next;
    logic [6:0]  rem_reg, rem_next;
    logic [6:0]  dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  trial;

    // load the operands on start, else shift one dividend bit into the remainder and try a subtract
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[28]};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 5'd28;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next  = 7'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[27:0], 1'b1};
            end else begin
                rem_next  = trial[6:0];
                quot_next = {quot_reg[27:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        cnt_reg  <= cnt_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

### hw/rtl/battery_cell_tap_monitor.sv
// battery_cell_tap_monitor: top level, sequencer, window memory and config.
// Depends on bctm_pkg and bctm_divider.
//
//  channel | dir | beat contents
//  s_axis  | in  | tdata: tap_code_0..tap_code_7, 16 bits each
//  m_axis  | out | tdata: cell fields and scan statistics; tlast: last_cell
//  apb     | cfg | five registers at 4*i
//
// With every tap good a scan does per tap one write, count+1 sum reads (count
// being the filled window length), the divide, the multiply and saturate steps and
// the cell step; then the stats pass over the eight taps, eight result beats and a
// return to idle. A bad or offline tap goes from its write straight to its cell step.
// After reset the windows are cleared, one entry a cycle. A stalled m_axis holds the
// current result; no scan is accepted until all eight results are taken.
module battery_cell_tap_monitor #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // tap_code_0 .. tap_code_7, 16 bits each
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cell_index[2:0], cell_mv[19:3], cell_safe[20], total_mv[40:21],
    // min_cell_mv[57:41], max_cell_mv[74:58], avg_cell_mv[91:75],
    // cell_spread_mv[108:92], data_valid[109], zero fill
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast,   // last_cell
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int MEM_DEPTH = bctm_pkg::TAPS * (1 << AW);
    localparam int MAW = AW + 3;

    // configuration registers
    logic [23:0] scale_reg;
    logic [15:0] under_reg, over_reg;
    logic        grp_a_reg, grp_b_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 24'd61440;
            under_reg <= 16'd2500;
            over_reg  <= 16'd3650;
            grp_a_reg <= 1'b1;
            grp_b_reg <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bctm_pkg::REG_SCALE:   scale_reg <= pwdata[23:0];
                bctm_pkg::REG_UNDER:   under_reg <= pwdata[15:0];
                bctm_pkg::REG_OVER:    over_reg  <= pwdata[15:0];
                bctm_pkg::REG_GROUP_A: grp_a_reg <= pwdata[0];
                bctm_pkg::REG_GROUP_B: grp_b_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bctm_pkg::REG_SCALE:   prdata = {8'd0, scale_reg};
            bctm_pkg::REG_UNDER:   prdata = {16'd0, under_reg};
            bctm_pkg::REG_OVER:    prdata = {16'd0, over_reg};
            bctm_pkg::REG_GROUP_A: prdata = {31'd0, grp_a_reg};
            bctm_pkg::REG_GROUP_B: prdata = {31'd0, grp_b_reg};
            default:               prdata = '0;
        endcase
    end

    // window memory
    logic [14:0]    win_mem [MEM_DEPTH];
    logic           mem_we;
    logic [MAW-1:0] mem_waddr, mem_raddr;
    logic [14:0]    mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) win_mem[mem_waddr] <= mem_wdata;
        mem_rdata <= win_mem[mem_raddr];
    end

    // sequencer state
    bctm_pkg::state_t state_reg, state_next;
    logic [127:0]    codes_reg;
    logic [2:0]      tap_reg;
    logic [CW-1:0]   idx_reg;          // window walk, one extra for read latency
    logic [AW-1:0]   slot_reg;
    logic            full_reg;
    logic [MAW-1:0]  clr_reg;
    logic [28:0]     sum_reg;          // sum << 8 sits in the divider input
    logic [16:0]     stack_reg [bctm_pkg::TAPS];
    logic [16:0]     cell_reg  [bctm_pkg::TAPS];
    logic            valid_reg;
    logic [19:0]     total_reg;
    logic [16:0]     lo_reg, hi_reg;
    logic [46:0]     prod_reg;
    logic            mul_ph_reg;

    logic [15:0]     code_cur;
    logic            online_cur, good_cur;
    logic [CW-1:0]   count;
    logic [28:0]     sum_add;
    bctm_pkg::div_req_t dreq;
    bctm_pkg::div_rsp_t drsp;

    assign code_cur   = codes_reg[16*tap_reg +: 16];
    assign online_cur = tap_reg[2] ? grp_b_reg : grp_a_reg;
    assign good_cur   = online_cur && !code_cur[15];
    assign count      = full_reg ? CW'(WINDOW_DEPTH) : CW'({1'b0, slot_reg} + 1);
    assign sum_add    = sum_reg + {6'd0, mem_rdata, 8'd0};

    bctm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bctm_pkg::ST_CLEAR:
                if (clr_reg == MAW'(MEM_DEPTH - 1)) state_next = bctm_pkg::ST_IDLE;
            bctm_pkg::ST_IDLE:
                if (s_axis_tvalid) state_next = bctm_pkg::ST_WRITE;
            bctm_pkg::ST_WRITE:
                state_next = good_cur ? bctm_pkg::ST_SUM : bctm_pkg::ST_CELL;
            bctm_pkg::ST_SUM:
                if (idx_reg == count) state_next = bctm_pkg::ST_DIV;
            bctm_pkg::ST_DIV:
                if (drsp.done) state_next = bctm_pkg::ST_MUL;
            bctm_pkg::ST_MUL:
                if (mul_ph_reg) state_next = bctm_pkg::ST_CELL;
            bctm_pkg::ST_CELL:
                state_next = (tap_reg == 3'd7) ? bctm_pkg::ST_STATS
                                               : bctm_pkg::ST_WRITE;
            bctm_pkg::ST_STATS:
                if (tap_reg == 3'd7) state_next = bctm_pkg::ST_EMIT;
            bctm_pkg::ST_EMIT:
                if (m_axis_tready && tap_reg == 3'd7) state_next = bctm_pkg::ST_IDLE;
            default: state_next = bctm_pkg::ST_IDLE;
        endcase
    end

    // memory and divider controls; the last window entry joins the sum on the way in
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {tap_reg, slot_reg};
        mem_wdata = code_cur[14:0];
        mem_raddr = {tap_reg, AW'(idx_reg)};
        dreq.start    = 1'b0;
        dreq.dividend = sum_add;
        dreq.divisor  = 7'(count);
        case (state_reg)
            bctm_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            bctm_pkg::ST_WRITE: mem_we = good_cur;
            bctm_pkg::ST_SUM:   dreq.start = (idx_reg == count);
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == bctm_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == bctm_pkg::ST_EMIT);
    assign m_axis_tlast  = (tap_reg == 3'd7);

    // scaled product, saturated to 16 bits
    logic [46:0] prod_sh;
    logic [16:0] mv_sat;
    assign prod_sh = prod_reg >> 24;
    assign mv_sat  = (prod_sh > 47'd65535) ? 17'd65535 : 17'(prod_sh);

    logic [16:0] cell_now;
    logic [16:0] stack_lo;
    assign stack_lo = (tap_reg == 3'd0) ? 17'd0 : stack_reg[tap_reg - 3'd1];
    assign cell_now = 17'(stack_reg[tap_reg] - stack_lo);

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bctm_pkg::ST_CLEAR;
            clr_reg   <= '0;
            slot_reg  <= '0;
            full_reg  <= 1'b0;
            tap_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                bctm_pkg::ST_CLEAR: clr_reg <= MAW'(clr_reg + 1'b1);
                bctm_pkg::ST_IDLE: begin
                    codes_reg <= s_axis_tdata;
                    tap_reg   <= '0;
                    valid_reg <= 1'b1;
                end
                bctm_pkg::ST_WRITE: begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                    if (!good_cur) begin
                        valid_reg          <= 1'b0;
                        stack_reg[tap_reg] <= '0;
                    end
                end
                bctm_pkg::ST_SUM: begin
                    idx_reg <= CW'(idx_reg + 1'b1);
                    if (idx_reg != '0)
                        sum_reg <= sum_add;
                end
                bctm_pkg::ST_DIV: mul_ph_reg <= 1'b0;
                bctm_pkg::ST_MUL: begin
                    if (!mul_ph_reg)
                        prod_reg <= 47'(drsp.quotient[22:0] * scale_reg);
                    else
                        stack_reg[tap_reg] <= mv_sat;
                    mul_ph_reg <= 1'b1;
                end
                bctm_pkg::ST_CELL: begin
                    tap_reg <= tap_reg + 3'd1;
                    if (tap_reg == 3'd7) begin
                        slot_reg <= (slot_reg == AW'(WINDOW_DEPTH - 1)) ? '0
                                                                         : AW'(slot_reg + 1'b1);
                        if (slot_reg == AW'(WINDOW_DEPTH - 1)) full_reg <= 1'b1;
                    end
                end
                bctm_pkg::ST_STATS: begin
                    cell_reg[tap_reg] <= cell_now;
                    if (tap_reg == 3'd0) begin
                        total_reg <= 20'(signed'(cell_now));
                        lo_reg    <= cell_now;
                        hi_reg    <= cell_now;
                    end else begin
                        total_reg <= total_reg + 20'(signed'(cell_now));
                        if (signed'(cell_now) < signed'(lo_reg)) lo_reg <= cell_now;
                        if (signed'(cell_now) > signed'(hi_reg)) hi_reg <= cell_now;
                    end
                    tap_reg <= tap_reg + 3'd1;
                end
                bctm_pkg::ST_EMIT:
                    if (m_axis_tready) tap_reg <= tap_reg + 3'd1;
                default: ;
            endcase
        end
    end

    // result beat
    logic [16:0] cur_cell;
    logic        cur_safe;
    logic [19:0] avg_full;
    assign cur_cell = cell_reg[tap_reg];
    assign cur_safe = !cur_cell[16] && (cur_cell[15:0] >= under_reg)
                      && (cur_cell[15:0] <= over_reg);
    assign avg_full = 20'(signed'(total_reg + (total_reg[19] ? 20'd7 : 20'd0)) >>> 3);

    assign m_axis_tdata = {2'b00, valid_reg, 17'(hi_reg - lo_reg), avg_full[16:0],
                           hi_reg, lo_reg, total_reg, cur_safe, cur_cell, tap_reg};

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for battery_cell_tap_monitor, driving tap scans and
// configuration writes and checking every cell beat against a local scan predictor.
// Depends on bctm_pkg and the battery_cell_tap_monitor RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  cell_index;
        logic [16:0] cell_mv;
        logic        cell_safe;
        logic [19:0] total_mv;
        logic [16:0] min_cell_mv;
        logic [16:0] max_cell_mv;
        logic [16:0] avg_cell_mv;
        logic [16:0] cell_spread_mv;
        logic        data_valid;
        logic        last_cell;
    } cell_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    battery_cell_tap_monitor #(.WINDOW_DEPTH(DEPTH)) dut (.*);

    // predictor state: configuration copy and tap windows
    logic [23:0] scale_q16;
    logic [15:0] under_mv, over_mv;
    logic        grp_a_on, grp_b_on;
    logic [14:0] tap_window [8][DEPTH];
    int unsigned slot;
    bit          wrapped;

    logic [127:0] scan_queue [$];
    cell_beat_t   expected_cells [$];
    int  mismatches = 0;
    int  scans_sent = 0;
    int  cells_seen = 0;
    int  quiet_cycles = 0;
    bit  tx_idle_ok = 1'b1;
    bit  rx_idle_ok = 1'b1;
    bit  feed_hold = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // work out the eight cell beats of one scan and advance the windows
    task automatic predict_scan(input logic [127:0] codes);
        int          stack [8];
        int          cell_val [8];
        bit          ok;
        int          total, lo, hi, avg;
        int unsigned cnt;
        longint unsigned sum, mean_q8, mv;
        cell_beat_t  b;
        logic [15:0] c;
        ok = 1'b1;
        cnt = wrapped ? DEPTH : slot + 1;
        for (int t = 0; t < 8; t++) begin
            c = codes[16*t +: 16];
            if (!((t < 4) ? grp_a_on : grp_b_on) || c[15]) begin
                ok = 1'b0;
                stack[t] = 0;
            end else begin
                tap_window[t][slot] = c[14:0];
                sum = 0;
                for (int i = 0; i < cnt; i++) sum += tap_window[t][i];
                mean_q8 = (sum << 8) / cnt;
                mv = (mean_q8 * scale_q16) >> 24;
                stack[t] = (mv > 65535) ? 65535 : int'(mv);
            end
        end
        total = 0;
        for (int t = 0; t < 8; t++) begin
            cell_val[t] = (t == 0) ? stack[0] : stack[t] - stack[t-1];
        end
        lo = cell_val[0];
        hi = cell_val[0];
        for (int t = 0; t < 8; t++) begin
            total += cell_val[t];
            if (cell_val[t] < lo) lo = cell_val[t];
            if (cell_val[t] > hi) hi = cell_val[t];
        end
        avg = total / 8;
        for (int t = 0; t < 8; t++) begin
            b.cell_index     = 3'(t);
            b.cell_mv        = 17'(cell_val[t]);
            b.cell_safe      = cell_val[t] >= int'(under_mv) && cell_val[t] <= int'(over_mv);
            b.total_mv       = 20'(total);
            b.min_cell_mv    = 17'(lo);
            b.max_cell_mv    = 17'(hi);
            b.avg_cell_mv    = 17'(avg);
            b.cell_spread_mv = 17'(hi - lo);
            b.data_valid     = ok;
            b.last_cell      = (t == 7);
            expected_cells.push_back(b);
        end
        slot = (slot + 1) % DEPTH;
        if (slot == 0) wrapped = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at cell beat %0d: %s got %0h want %0h", cells_seen, what, got, want);
    endtask

    // APB write: setup then access; mirror the value into the predictor
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            bctm_pkg::REG_SCALE:   scale_q16 = val[23:0];
            bctm_pkg::REG_UNDER:   under_mv  = val[15:0];
            bctm_pkg::REG_OVER:    over_mv   = val[15:0];
            bctm_pkg::REG_GROUP_A: grp_a_on  = val[0];
            bctm_pkg::REG_GROUP_B: grp_b_on  = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_code();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(32768, 65535));
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 32767));
        endcase
    endfunction

    // rising stack: cumulative codes, so cells come out mostly positive
    function automatic logic [127:0] stack_scan(input int step_hi);
        logic [127:0] s;
        int acc;
        acc = 0;
        for (int t = 0; t < 8; t++) begin
            acc += $urandom_range(0, step_hi);
            if (acc > 32767) acc = 32767;
            s[16*t +: 16] = 16'(acc);
        end
        if ($urandom_range(0, 19) == 0) s[16*$urandom_range(0, 7) +: 16] = rand_code() | 16'h8000;
        return s;
    endfunction

    function automatic logic [127:0] noise_scan();
        logic [127:0] s;
        for (int t = 0; t < 8; t++) s[16*t +: 16] = rand_code();
        return s;
    endfunction

    task automatic wait_drained();
        while (scan_queue.size() != 0 || s_axis_tvalid || expected_cells.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // drive scans from the queue; hold tvalid until the beat is taken
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_scan(s_axis_tdata);
                scans_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (scan_queue.size() != 0 && !feed_hold &&
                    !(tx_idle_ok && $urandom_range(0, 99) < 34)) begin
                    s_axis_tdata  <= scan_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // take result beats and compare against the oldest expectation
    always @(posedge aclk) begin
        cell_beat_t got, want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{cell_index: m_axis_tdata[2:0], cell_mv: m_axis_tdata[19:3],
                        cell_safe: m_axis_tdata[20], total_mv: m_axis_tdata[40:21],
                        min_cell_mv: m_axis_tdata[57:41], max_cell_mv: m_axis_tdata[74:58],
                        avg_cell_mv: m_axis_tdata[91:75],
                        cell_spread_mv: m_axis_tdata[108:92],
                        data_valid: m_axis_tdata[109], last_cell: m_axis_tlast};
                if (expected_cells.size() == 0) begin
                    report_mismatch("unexpected beat", got.cell_index, 0);
                end else begin
                    want = expected_cells.pop_front();
                    if (got.cell_index != want.cell_index)
                        report_mismatch("cell_index", got.cell_index, want.cell_index);
                    if (got.cell_mv != want.cell_mv)
                        report_mismatch("cell_mv", got.cell_mv, want.cell_mv);
                    if (got.cell_safe != want.cell_safe)
                        report_mismatch("cell_safe", got.cell_safe, want.cell_safe);
                    if (got.total_mv != want.total_mv)
                        report_mismatch("total_mv", got.total_mv, want.total_mv);
                    if (got.min_cell_mv != want.min_cell_mv)
                        report_mismatch("min_cell_mv", got.min_cell_mv, want.min_cell_mv);
                    if (got.max_cell_mv != want.max_cell_mv)
                        report_mismatch("max_cell_mv", got.max_cell_mv, want.max_cell_mv);
                    if (got.avg_cell_mv != want.avg_cell_mv)
                        report_mismatch("avg_cell_mv", got.avg_cell_mv, want.avg_cell_mv);
                    if (got.cell_spread_mv != want.cell_spread_mv)
                        report_mismatch("cell_spread_mv", got.cell_spread_mv,
                                        want.cell_spread_mv);
                    if (got.data_valid != want.data_valid)
                        report_mismatch("data_valid", got.data_valid, want.data_valid);
                    if (got.last_cell != want.last_cell)
                        report_mismatch("last_cell", got.last_cell, want.last_cell);
                end
                cells_seen++;
            end
            m_axis_tready <= !(rx_idle_ok && $urandom_range(0, 99) < 34);
        end
    end

    // watchdog: give up after a long run of cycles with no beat moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d beats pending", expected_cells.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [127:0] s;
        scale_q16 = 24'd61440; under_mv = 16'd2500; over_mv = 16'd3650;
        grp_a_on = 1'b1; grp_b_on = 1'b1;
        slot = 0; wrapped = 1'b0;
        for (int t = 0; t < 8; t++)
            for (int i = 0; i < DEPTH; i++) tap_window[t][i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: extremes, bad codes, window filling and wrap
        scan_queue.push_back('0);
        scan_queue.push_back({8{16'h7FFF}});
        scan_queue.push_back({8{16'hFFFF}});
        scan_queue.push_back({8{16'h8000}});
        scan_queue.push_back({16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000,
                              16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000});
        for (int i = 0; i < 10; i++) scan_queue.push_back(stack_scan(2200));
        wait_drained();

        // huge scale saturates, under above over gives no safe cell
        reg_write(bctm_pkg::REG_SCALE, 32'hFFFFFFFF);
        reg_write(bctm_pkg::REG_UNDER, 32'd65535);
        reg_write(bctm_pkg::REG_OVER, 32'd0);
        scan_queue.push_back({8{16'h7FFF}});
        scan_queue.push_back(stack_scan(4000));
        scan_queue.push_back(noise_scan());
        wait_drained();

        // offline groups leave their windows alone
        reg_write(bctm_pkg::REG_SCALE, 32'd0);
        reg_write(bctm_pkg::REG_GROUP_A, 32'd0);
        reg_write(bctm_pkg::REG_UNDER, 32'd0);
        reg_write(bctm_pkg::REG_OVER, 32'hFFFF);
        scan_queue.push_back(stack_scan(4000));
        wait_drained();
        reg_write(bctm_pkg::REG_SCALE, 32'd61440);
        scan_queue.push_back(stack_scan(4000));
        wait_drained();
        reg_write(bctm_pkg::REG_GROUP_A, 32'd1);
        reg_write(bctm_pkg::REG_GROUP_B, 32'd0);
        scan_queue.push_back(stack_scan(4000));
        scan_queue.push_back(stack_scan(4000));
        wait_drained();
        reg_write(bctm_pkg::REG_GROUP_B, 32'd1);
        reg_write(bctm_pkg::REG_UNDER, 32'd2500);
        reg_write(bctm_pkg::REG_OVER, 32'd3650);

        // random phases: mostly realistic stacks, some noise, varied settings
        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_ok = (ph != 2);
            rx_idle_ok = (ph != 2);
            for (int i = 0; i < 68; i++) begin
                if ($urandom_range(0, 4) == 0) s = noise_scan();
                else s = stack_scan((ph % 2) ? 6000 : 1500);
                scan_queue.push_back(s);
                if (i == 30 && ph == 1) begin
                    // pause the feed until every expected beat is back
                    feed_hold = 1'b1;
                    while (expected_cells.size() != 0 || s_axis_tvalid) @(posedge aclk);
                    feed_hold = 1'b0;
                end
            end
            wait_drained();
            reg_write(bctm_pkg::REG_SCALE,
                      (ph == 3) ? 32'hFFFFFF : $urandom_range(30000, 300000));
            reg_write(bctm_pkg::REG_UNDER, $urandom_range(0, 4000));
            reg_write(bctm_pkg::REG_OVER, $urandom_range(2000, 65535));
            reg_write(bctm_pkg::REG_GROUP_A, (ph == 4) ? 32'd0 : 32'd1);
            reg_write(bctm_pkg::REG_GROUP_B, 32'd1);
        end
        wait_drained();

        $display("covered %0d scans and %0d cell beats over several scale, limit and group settings",
                 scans_sent, cells_seen);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### battery_cell_tap_monitor.f
hw/rtl/bctm_pkg.sv
hw/rtl/bctm_divider.sv
hw/rtl/battery_cell_tap_monitor.sv
bench/tb_top.sv
